// File: rtl/kmsc_pkg.sv
`default_nettype none

package kmsc_pkg;

	localparam int unsigned VAL_W     = 7;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned S_DATA_W  = 16;
	localparam int unsigned M_DATA_W  = 32;

	// menu modes; the fourth code is unreachable from reset but still has defined behavior
	localparam logic [MODE_W-1:0] MODE_MAIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TIME = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEMP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSV  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOURS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HOURS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP  = 2'd3;

	localparam logic [VAL_W-1:0] RST_MAX_HOURS = 7'd24;
	localparam logic [VAL_W-1:0] RST_MIN_HOURS = 7'd0;
	localparam logic [VAL_W-1:0] RST_MIN_TEMP  = 7'd45;
	localparam logic [VAL_W-1:0] RST_MAX_TEMP  = 7'd65;
	localparam logic [VAL_W-1:0] RST_SETPOINT  = 7'd45;

	// knob range in the main menu selects a sub-menu
	localparam logic [VAL_W-1:0] MAIN_COUNT_MAX = 7'd2;
	localparam logic [VAL_W-1:0] MAIN_COUNT_MIN = 7'd1;

	typedef struct packed {
		logic             heat_timer_flag;
		logic             timer_start;
		logic             timer_stop;
		logic             commit_temp;
		logic [VAL_W-1:0] setpoint_temp;
		logic [VAL_W-1:0] hours_value;
		logic             commit_hours;
		logic [VAL_W-1:0] knob_count;
		logic [MODE_W-1:0] menu_mode;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/knob_menu_setpoint_controller_top.sv
// channel   dir  tvalid/tready       payload
// s_*       in   s_tvalid/s_tready   s_tuser = op, s_tdata = knob/button sample
// m_*       out  m_tvalid/m_tready   m_tdata = mode, count, hours, setpoint, commit and timer flags
// cfg_*     in   cfg_we              cfg_index, cfg_data (no handshake, no read-back)
//
// One request per clock while s_tready is high. The state update is a single
// pass of compare and +/-1 logic, and the result is captured in a one-deep
// output register on acceptance. s_tready = !m_tvalid | m_tready, so a held result only
// blocks input while m_tready is low. arst_n clears state to the main menu,
// count 0, setpoint 45 and the limit registers to their defaults.
`default_nettype none

module knob_menu_setpoint_controller_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// [0] op
	input  wire logic                          s_tuser,
	// [0] enc_a, [1] enc_b, [2] button, [9:3] remaining_hours, [10] timer_running
	input  wire logic [kmsc_pkg::S_DATA_W-1:0]  s_tdata,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [1:0] menu_mode, [8:2] knob_count, [9] commit_hours, [16:10] hours_value,
	// [23:17] setpoint_temp, [24] commit_temp, [25] timer_stop, [26] timer_start,
	// [27] heat_timer_flag
	output      logic [kmsc_pkg::M_DATA_W-1:0]  m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [kmsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kmsc_pkg::VAL_W-1:0]     cfg_data
);
	import kmsc_pkg::*;

	logic [VAL_W-1:0]  max_hours_q, min_hours_q, min_temp_q, max_temp_q;
	logic              a_ref_q, held_q;
	logic [MODE_W-1:0] mode_q;
	logic [VAL_W-1:0]  count_q, setp_q;

	logic              a_ref_d, held_d;
	logic [MODE_W-1:0] mode_d;
	logic [VAL_W-1:0]  count_d, setp_d;
	result_t           res_d, res_q;
	logic              m_tvalid_q;

	logic             enc_a, enc_b, button, timer_running, accept;
	logic [VAL_W-1:0] remaining_hours;

	assign enc_a           = s_tdata[0];
	assign enc_b           = s_tdata[1];
	assign button          = s_tdata[2];
	assign remaining_hours = s_tdata[9:3];
	assign timer_running   = s_tdata[10];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, res_q};

	always_comb begin
		a_ref_d = a_ref_q;
		held_d  = held_q;
		mode_d  = mode_q;
		count_d = count_q;
		setp_d  = setp_q;
		res_d   = '0;

		if (!s_tuser) begin
			if (enc_a != a_ref_q) begin
				if (enc_b == a_ref_q) begin
					unique case (mode_q)
						MODE_MAIN: if (count_q < MAIN_COUNT_MAX) count_d = count_q + 7'd1;
						MODE_TIME: if (count_q < max_hours_q) count_d = count_q + 7'd1;
						MODE_TEMP: begin
							priority if (count_q < min_temp_q) count_d = min_temp_q;
							else if (count_q < max_temp_q) count_d = count_q + 7'd1;
						end
						MODE_RSV: ;
					endcase
				end else begin
					unique case (mode_q)
						MODE_MAIN: if (count_q > MAIN_COUNT_MIN) count_d = count_q - 7'd1;
						MODE_TEMP: begin
							if (count_q > min_temp_q) count_d = count_q - 7'd1;
							else count_d = min_temp_q;
						end
						MODE_TIME, MODE_RSV: if (count_q > min_hours_q) count_d = count_q - 7'd1;
					endcase
				end
			end else begin
				// same level as reference: rearm for the opposite edge
				a_ref_d = ~enc_a;
			end
		end else if (button && !held_q) begin
			held_d = 1'b1;
			unique case (mode_q)
				MODE_MAIN: begin
					mode_d = count_q[MODE_W-1:0];
					if (count_q[MODE_W-1:0] == MODE_TIME) begin
						res_d.timer_stop = 1'b1;
						count_d = remaining_hours;
					end else if (count_q[MODE_W-1:0] == MODE_TEMP) begin
						count_d = setp_q;
					end
				end
				MODE_TIME: begin
					mode_d             = MODE_MAIN;
					res_d.commit_hours = 1'b1;
					res_d.hours_value  = count_q;
					if (count_q != '0) begin
						res_d.timer_start     = 1'b1;
						res_d.heat_timer_flag = 1'b1;
					end
					count_d = '0;
				end
				MODE_TEMP: begin
					mode_d                = MODE_MAIN;
					setp_d                = count_q;
					res_d.commit_temp     = 1'b1;
					res_d.heat_timer_flag = timer_running;
					count_d               = '0;
				end
				MODE_RSV: ;
			endcase
		end else if (!button && held_q) begin
			held_d = 1'b0;
		end

		res_d.menu_mode     = mode_d;
		res_d.knob_count    = count_d;
		res_d.setpoint_temp = setp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hours_q <= RST_MAX_HOURS;
			min_hours_q <= RST_MIN_HOURS;
			min_temp_q  <= RST_MIN_TEMP;
			max_temp_q  <= RST_MAX_TEMP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_HOURS: max_hours_q <= cfg_data;
				REG_MIN_HOURS: min_hours_q <= cfg_data;
				REG_MIN_TEMP:  min_temp_q  <= cfg_data;
				REG_MAX_TEMP:  max_temp_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_ref_q    <= 1'b0;
			held_q     <= 1'b0;
			mode_q     <= MODE_MAIN;
			count_q    <= '0;
			setp_q     <= RST_SETPOINT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				a_ref_q <= a_ref_d;
				held_q  <= held_d;
				mode_q  <= mode_d;
				count_q <= count_d;
				setp_q  <= setp_d;
			end
			if (accept) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res_d;
	end

endmodule

`default_nettype wire

// File: rtl/kmsc_checker.sv
`default_nettype none

module kmsc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [kmsc_pkg::M_DATA_W-1:0]  m_tdata
);
	import kmsc_pkg::*;

	// held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted request shows a result next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request gave no result");

	a_mode_reach: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != MODE_RSV)
		else $error("unreachable menu mode");

	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[9] && m_tdata[24]))
		else $error("hours and temperature committed together");

	// a commit returns to main with the count cleared
	a_commit_main: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9] || m_tdata[24]) |->
			m_tdata[1:0] == MODE_MAIN && m_tdata[8:2] == '0)
		else $error("commit without return to main");

endmodule

bind knob_menu_setpoint_controller_top kmsc_checker u_kmsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
